### hdl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants, register codes, control types and helpers for the
// box filter downscaler.
// ----------------------------------------------------------------------------
package bfd_pkg;

  // default limits, handed to the top level parameters
  localparam int DEF_MAX_OUT_WIDTH = 1024;
  localparam int DEF_MAX_SCALE     = 16;
  localparam int DEF_MAX_SRC_DIM   = 4096;

  // pixel layout
  localparam int CH_N    = 4;
  localparam int PIX_W   = 8;
  localparam int TDATA_W = CH_N * PIX_W;

  // configuration register widths
  localparam int SRC_DIM_CW = 13;
  localparam int OUT_DIM_CW = 11;
  localparam int SCALE_CW   = 5;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_X    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_Y    = 3'd5;

  // per-pixel control from the position counters
  typedef struct packed {
    logic active;  // pixel lies inside the used area
    logic first;   // first pixel of its block
    logic done;    // bottom-right pixel of its block
    logic last;    // lies in the bottom row of the final block
  } ctl_flags_t;

  // zero acts as one, values above the limit act as the limit
  function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/bfd_sum_ram.sv
// ----------------------------------------------------------------------------
// bfd_sum_ram
// Column accumulator memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfd_sum_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/bfd_position.sv
// ----------------------------------------------------------------------------
// bfd_position
// Configuration registers and raster position counters; classifies each
// source pixel and gives its accumulator column and the block divisor.
// ----------------------------------------------------------------------------
module bfd_position
  import bfd_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_SCALE     = DEF_MAX_SCALE,
  parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM,
  localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
  localparam int SC_W   = $clog2(MAX_SCALE + 1),
  localparam int N_W    = 2 * SC_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   step,
  output ctl_flags_t             flags,
  output logic [ADDR_W-1:0]      addr,
  output logic [N_W-1:0]         divisor
);

  localparam int SW_W   = $clog2(MAX_SRC_DIM + 1);
  localparam int SCOL_W = $clog2(MAX_SRC_DIM);
  localparam int OW_W   = $clog2(MAX_OUT_WIDTH + 1);
  localparam int BLK_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int UW_W   = OW_W + SC_W;
  localparam int UH_W   = OUT_DIM_CW + SC_W;

  // configuration registers
  logic [SRC_DIM_CW-1:0] src_width;
  logic [SRC_DIM_CW-1:0] src_height;
  logic [OUT_DIM_CW-1:0] out_width;
  logic [OUT_DIM_CW-1:0] out_height;
  logic [SCALE_CW-1:0]   scale_x;
  logic [SCALE_CW-1:0]   scale_y;

  // position counters
  logic [SCOL_W-1:0] source_column, source_column_next;
  logic [SCOL_W-1:0] source_row, source_row_next;
  logic [BLK_W-1:0]  row_in_block, row_in_block_next;
  logic [BLK_W-1:0]  column_in_block, column_in_block_next;
  logic [OW_W-1:0]   output_column, output_column_next;

  logic [SW_W-1:0]       sw;
  logic [SW_W-1:0]       sh;
  logic [OW_W-1:0]       ow;
  logic [OUT_DIM_CW-1:0] oh;
  logic [SC_W-1:0]       sx;
  logic [SC_W-1:0]       sy;
  logic [UW_W-1:0]       used_w;
  logic [UH_W-1:0]       used_h;
  logic [SCOL_W:0]       scol_inc;
  logic [SCOL_W:0]       srow_inc;
  logic [BLK_W:0]        cib_inc;
  logic [BLK_W:0]        rib_inc;
  logic                  in_rng;

  // effective sizes
  assign sw      = SW_W'(clamp_reg(32'(src_width), 32'(MAX_SRC_DIM)));
  assign sh      = SW_W'(clamp_reg(32'(src_height), 32'(MAX_SRC_DIM)));
  assign ow      = OW_W'(clamp_reg(32'(out_width), 32'(MAX_OUT_WIDTH)));
  assign oh      = (out_height == '0) ? OUT_DIM_CW'(1) : out_height;
  assign sx      = SC_W'(clamp_reg(32'(scale_x), 32'(MAX_SCALE)));
  assign sy      = SC_W'(clamp_reg(32'(scale_y), 32'(MAX_SCALE)));
  assign used_w  = UW_W'(ow) * UW_W'(sx);
  assign used_h  = UH_W'(oh) * UH_W'(sy);
  assign divisor = N_W'(sx) * N_W'(sy);

  assign scol_inc = {1'b0, source_column} + (SCOL_W + 1)'(1);
  assign srow_inc = {1'b0, source_row} + (SCOL_W + 1)'(1);
  assign cib_inc  = {1'b0, column_in_block} + (BLK_W + 1)'(1);
  assign rib_inc  = {1'b0, row_in_block} + (BLK_W + 1)'(1);

  // classify the current pixel
  assign in_rng = (32'(source_column) < 32'(used_w)) && (32'(source_row) < 32'(used_h)) &&
                  (32'(output_column) < 32'(ow));
  assign flags.active = in_rng;
  assign flags.first  = (row_in_block == '0) && (column_in_block == '0);
  assign flags.done   = (32'(row_in_block) == 32'(sy) - 32'd1) &&
                        (32'(column_in_block) == 32'(sx) - 32'd1);
  assign flags.last   = (32'(output_column) == 32'(ow) - 32'd1) &&
                        (32'(source_row) == 32'(used_h) - 32'd1);
  assign addr         = output_column[ADDR_W-1:0];

  // advance the raster position
  always_comb begin
    source_column_next   = source_column;
    source_row_next      = source_row;
    row_in_block_next    = row_in_block;
    column_in_block_next = column_in_block;
    output_column_next   = output_column;
    if (in_rng) begin
      if (32'(cib_inc) >= 32'(sx)) begin
        column_in_block_next = '0;
        output_column_next   = output_column + OW_W'(1);
      end else begin
        column_in_block_next = cib_inc[BLK_W-1:0];
      end
    end
    if (32'(scol_inc) >= 32'(sw)) begin
      source_column_next   = '0;
      column_in_block_next = '0;
      output_column_next   = '0;
      if (32'(source_row) < 32'(used_h)) begin
        row_in_block_next = (32'(rib_inc) >= 32'(sy)) ? '0 : rib_inc[BLK_W-1:0];
      end
      if (32'(srow_inc) >= 32'(sh)) begin
        source_row_next   = '0;
        row_in_block_next = '0;
      end else begin
        source_row_next = srow_inc[SCOL_W-1:0];
      end
    end else begin
      source_column_next = scol_inc[SCOL_W-1:0];
    end
  end

  // register writes restart the image, pixels step the counters
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= SRC_DIM_CW'(1);
      src_height      <= SRC_DIM_CW'(1);
      out_width       <= OUT_DIM_CW'(1);
      out_height      <= OUT_DIM_CW'(1);
      scale_x         <= SCALE_CW'(1);
      scale_y         <= SCALE_CW'(1);
      source_column   <= '0;
      source_row      <= '0;
      row_in_block    <= '0;
      column_in_block <= '0;
      output_column   <= '0;
    end else if (cfg_write && (cfg_index <= CFG_SCALE_Y)) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data;
        CFG_SRC_HEIGHT: src_height <= cfg_data;
        CFG_OUT_WIDTH:  out_width  <= cfg_data[OUT_DIM_CW-1:0];
        CFG_OUT_HEIGHT: out_height <= cfg_data[OUT_DIM_CW-1:0];
        CFG_SCALE_X:    scale_x    <= cfg_data[SCALE_CW-1:0];
        CFG_SCALE_Y:    scale_y    <= cfg_data[SCALE_CW-1:0];
        default: ;
      endcase
      source_column   <= '0;
      source_row      <= '0;
      row_in_block    <= '0;
      column_in_block <= '0;
      output_column   <= '0;
    end else if (step) begin
      source_column   <= source_column_next;
      source_row      <= source_row_next;
      row_in_block    <= row_in_block_next;
      column_in_block <= column_in_block_next;
      output_column   <= output_column_next;
    end
  end

endmodule

### hdl/bfd_divider.sv
// ----------------------------------------------------------------------------
// bfd_divider
// Pipelined restoring divider: block sums divided by the block size, one
// quotient bit per stage for all channels at once.
// ----------------------------------------------------------------------------
module bfd_divider
  import bfd_pkg::*;
#(
  parameter int SUM_W = 16,
  parameter int N_W   = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [CH_N-1:0][SUM_W-1:0]  in_sums,
  input  logic                        in_last,
  input  logic [N_W-1:0]              divisor,
  output logic                        out_valid,
  output logic [CH_N-1:0][PIX_W-1:0]  out_quo,
  output logic                        out_last
);

  localparam int STAGES = PIX_W;
  localparam int DW     = SUM_W + 1;

  logic [STAGES:0]    d_valid;
  logic [STAGES:0]    d_last;
  logic [DW-1:0]      d_rem [STAGES+1][CH_N];
  logic [PIX_W-1:0]   d_quo [STAGES+1][CH_N];

  // valid bits through the entry stage and the divide stages
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else if (en) begin
      d_valid <= {d_valid[STAGES-1:0], in_valid};
    end
  end

  // entry stage, then one quotient bit per stage, most significant first
  always_ff @(posedge clk) begin
    if (en) begin
      d_last <= {d_last[STAGES-1:0], in_last};
      for (int c = 0; c < CH_N; c++) begin
        d_rem[0][c] <= DW'(in_sums[c]);
        d_quo[0][c] <= '0;
      end
      for (int s = 1; s <= STAGES; s++) begin
        for (int c = 0; c < CH_N; c++) begin
          if (d_rem[s-1][c] >= (DW'(divisor) << (STAGES - s))) begin
            d_rem[s][c] <= d_rem[s-1][c] - (DW'(divisor) << (STAGES - s));
            d_quo[s][c] <= d_quo[s-1][c] | (PIX_W'(1) << (STAGES - s));
          end else begin
            d_rem[s][c] <= d_rem[s-1][c];
            d_quo[s][c] <= d_quo[s-1][c];
          end
        end
      end
    end
  end

  // final stage
  assign out_valid = d_valid[STAGES];
  assign out_last  = d_last[STAGES];

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      out_quo[c] = d_quo[STAGES][c];
    end
  end

endmodule

### hdl/box_filter_downscale_core.sv
// ----------------------------------------------------------------------------
// box_filter_downscale_core
// Integer box filter downscaler for RGBA pixel streams in raster order.
// Throughput: one source pixel per cycle; the accumulator memory does one
//   read and one write-back per cycle, with forwarding on back-to-back hits.
// Path: a block-completing pixel's mean reaches m_axis through the add stage,
//   the divider entry, 8 divide stages and the output register.
// Input stalls only when a result is blocked at the output and the divider
//   tail is full.
// Reset (sync, rst high): registers to 1, position and pipeline cleared; the
//   accumulator memory is not cleared, the first row of each block fills it.
// ----------------------------------------------------------------------------
module box_filter_downscale_core
  import bfd_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_SCALE     = DEF_MAX_SCALE,
  parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_W-1:0]     s_axis_tdata,   // src_red, src_green, src_blue, src_alpha
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_W-1:0]     m_axis_tdata,   // avg_red, avg_green, avg_blue, avg_alpha
  output logic                   m_axis_tlast    // last_of_image
);

  localparam int SUM_W  = PIX_W + $clog2(MAX_SCALE * MAX_SCALE);
  localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int SC_W   = $clog2(MAX_SCALE + 1);
  localparam int N_W    = 2 * SC_W;

  logic                        en;
  logic                        accept;
  ctl_flags_t                  pos_flags;
  logic [ADDR_W-1:0]           pos_addr;
  logic [N_W-1:0]              divisor;
  logic [CH_N-1:0][PIX_W-1:0]  in_pix;
  logic                        rd_en;
  logic [CH_N-1:0][SUM_W-1:0]  rd_sums;

  logic                        a_valid;
  ctl_flags_t                  a_flags;
  logic [ADDR_W-1:0]           a_addr;
  logic [CH_N-1:0][PIX_W-1:0]  a_pix;
  logic                        fwd;
  logic [CH_N-1:0][SUM_W-1:0]  last_wr;
  logic [CH_N-1:0][SUM_W-1:0]  old_sums;
  logic [CH_N-1:0][SUM_W-1:0]  new_sums;
  logic                        wr_en;

  logic                        div_valid;
  logic [CH_N-1:0][PIX_W-1:0]  div_quo;
  logic                        div_last;

  logic                        out_valid;
  logic [CH_N-1:0][PIX_W-1:0]  out_quo;
  logic                        out_last;

  // pipeline advances unless a finished result is blocked behind the output
  assign en            = !(div_valid && out_valid && !m_axis_tready);
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign in_pix        = s_axis_tdata;

  bfd_position #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_SCALE    (MAX_SCALE),
    .MAX_SRC_DIM  (MAX_SRC_DIM)
  ) u_position (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (accept),
    .flags    (pos_flags),
    .addr     (pos_addr),
    .divisor  (divisor)
  );

  // accumulator read on request, write-back from the add stage
  assign rd_en = accept && pos_flags.active;
  assign wr_en = en && a_valid;

  bfd_sum_ram #(
    .DEPTH (MAX_OUT_WIDTH),
    .ADDR_W(ADDR_W),
    .DATA_W(CH_N * SUM_W)
  ) u_sum_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(a_addr),
    .wr_data(new_sums),
    .rd_en  (rd_en),
    .rd_addr(pos_addr),
    .rd_data(rd_sums)
  );

  // add stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      fwd     <= 1'b0;
    end else if (en) begin
      a_valid <= rd_en;
      fwd     <= wr_en && rd_en && (a_addr == pos_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_flags <= pos_flags;
      a_addr  <= pos_addr;
      a_pix   <= in_pix;
    end
  end

  // keep the last write-back for a same-column read in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr <= new_sums;
    end
  end

  // overwrite on the first pixel of a block, add otherwise
  assign old_sums = fwd ? last_wr : rd_sums;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      new_sums[c] = a_flags.first ? SUM_W'(a_pix[c]) : old_sums[c] + SUM_W'(a_pix[c]);
    end
  end

  bfd_divider #(
    .SUM_W(SUM_W),
    .N_W  (N_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid && a_flags.done),
    .in_sums  (new_sums),
    .in_last  (a_flags.last),
    .divisor  (divisor),
    .out_valid(div_valid),
    .out_quo  (div_quo),
    .out_last (div_last)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_valid && en) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_valid && en) begin
      out_quo  <= div_quo;
      out_last <= div_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_quo;
  assign m_axis_tlast  = out_last;

endmodule

### test/tb_box_filter_downscale_core.sv
// ----------------------------------------------------------------------------
// tb_box_filter_downscale_core
// Self-checking bench for the box filter downscaler. Source pixels are
// streamed in bursts with random gaps, and the output side stalls on its own
// pattern. A built-in predictor tracks the block sums and the raster position
// and queues each averaged pixel. Every output request is compared field by
// field with the oldest queued pixel. Covered: reset defaults, small and
// largest blocks, zero and oversized registers, size mismatch, a long output
// stall and random frame setups.
// ----------------------------------------------------------------------------
module tb_box_filter_downscale_core;
  import bfd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 400;

  // averaged pixel, laid out as {tlast, tdata}
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } avg_pixel_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata = '0;   // src_red, src_green, src_blue, src_alpha
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]     m_axis_tdata;        // avg_red, avg_green, avg_blue, avg_alpha
  logic                   m_axis_tlast;        // last_of_image

  box_filter_downscale_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // predictor copy of the registers and the raster position
  logic [SRC_DIM_CW-1:0] src_w_reg = SRC_DIM_CW'(1), src_h_reg = SRC_DIM_CW'(1);
  logic [OUT_DIM_CW-1:0] out_w_reg = OUT_DIM_CW'(1), out_h_reg = OUT_DIM_CW'(1);
  logic [SCALE_CW-1:0]   scale_x_reg = SCALE_CW'(1), scale_y_reg = SCALE_CW'(1);
  int unsigned           col_pos, row_pos, blk_row, blk_col, out_col;
  int unsigned           block_sum [DEF_MAX_OUT_WIDTH][CH_N];
  avg_pixel_t            expected_avgs [$];

  int  pixels_sent, results_checked, setups, errors, cycles;
  int  burst_left;
  bit  tx_steady;
  int  holds_requested, holds_served, hold_left;
  int  rx_mode_left;
  rx_mode_t rx_mode;

  // zero acts as one, above the limit acts as the limit
  function automatic int unsigned eff_reg(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    blk_row = 0;
    blk_col = 0;
    out_col = 0;
  endfunction

  // advance the box filter by one source pixel, queue the mean of a finished block
  function automatic void predict_pixel(input logic [TDATA_W-1:0] px);
    int unsigned sw, sh, ow, oh, sx, sy, used_w, used_h, area;
    logic [TDATA_W-1:0] means;
    avg_pixel_t avg;
    sw = eff_reg(src_w_reg, DEF_MAX_SRC_DIM);
    sh = eff_reg(src_h_reg, DEF_MAX_SRC_DIM);
    ow = eff_reg(out_w_reg, DEF_MAX_OUT_WIDTH);
    oh = eff_reg(out_h_reg, 2047);
    sx = eff_reg(scale_x_reg, DEF_MAX_SCALE);
    sy = eff_reg(scale_y_reg, DEF_MAX_SCALE);
    used_w = ow * sx;
    used_h = oh * sy;
    if (col_pos < used_w && row_pos < used_h && out_col < ow) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        if (blk_row == 0 && blk_col == 0) begin
          block_sum[out_col][ch] = 32'(px[ch*PIX_W +: PIX_W]);
        end else begin
          block_sum[out_col][ch] += 32'(px[ch*PIX_W +: PIX_W]);
        end
      end
      if (blk_row == sy - 1 && blk_col == sx - 1) begin
        area = sx * sy;
        for (int ch = 0; ch < CH_N; ch++) begin
          means[ch*PIX_W +: PIX_W] = PIX_W'(block_sum[out_col][ch] / area);
        end
        avg = {(out_col == ow - 1 && row_pos == used_h - 1), means};
        expected_avgs = {expected_avgs, avg};
      end
      blk_col++;
      if (blk_col >= sx) begin
        blk_col = 0;
        out_col++;
      end
    end
    // end of a source row, then end of the source image
    col_pos++;
    if (col_pos >= sw) begin
      col_pos = 0;
      blk_col = 0;
      out_col = 0;
      if (row_pos < used_h) begin
        blk_row++;
        if (blk_row >= sy) blk_row = 0;
      end
      row_pos++;
      if (row_pos >= sh) begin
        row_pos = 0;
        blk_row = 0;
      end
    end
  endfunction

  // write all six registers, one per cycle, block must be idle
  task automatic program_regs(input int unsigned sw, input int unsigned sh,
                              input int unsigned ow, input int unsigned oh,
                              input int unsigned sx, input int unsigned sy);
    logic [CFG_INDEX_W-1:0] reg_order [6] = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_OUT_WIDTH,
                                              CFG_OUT_HEIGHT, CFG_SCALE_X, CFG_SCALE_Y};
    int unsigned vals [6];
    vals = '{sw, sh, ow, oh, sx, sy};
    cfg_write <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= reg_order[i];
      cfg_data  <= vals[i][CFG_DATA_W-1:0];
      @(posedge clk);
      case (reg_order[i])
        CFG_SRC_WIDTH:  src_w_reg   = vals[i][SRC_DIM_CW-1:0];
        CFG_SRC_HEIGHT: src_h_reg   = vals[i][SRC_DIM_CW-1:0];
        CFG_OUT_WIDTH:  out_w_reg   = vals[i][OUT_DIM_CW-1:0];
        CFG_OUT_HEIGHT: out_h_reg   = vals[i][OUT_DIM_CW-1:0];
        CFG_SCALE_X:    scale_x_reg = vals[i][SCALE_CW-1:0];
        CFG_SCALE_Y:    scale_y_reg = vals[i][SCALE_CW-1:0];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
    restart_frame();
    setups++;
  endtask

  // offer one source pixel, bursts separated by random gaps
  task automatic send_pixel(input logic [TDATA_W-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = tx_steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_pixel(px);
    pixels_sent++;
  endtask

  // stop sending, let all queued means arrive and the pipeline empty
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly random, sometimes every channel at zero or full scale
  function automatic logic [TDATA_W-1:0] random_pixel();
    logic [TDATA_W-1:0] px;
    px = $urandom;
    if ($urandom_range(0, 6) == 0) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        px[ch*PIX_W +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    end
    return px;
  endfunction

  function automatic int unsigned pick_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 8);
    return $urandom_range(9, 16);
  endfunction

  // registers at reset are all one: every pixel is its own image
  task automatic test_unity_defaults();
    logic [TDATA_W-1:0] px [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                   32'h5555_5555, 32'h0403_0201, 32'h8080_8080};
    tx_steady = 1'b1;
    foreach (px[i]) send_pixel(px[i]);
    wait_drained();
  endtask

  // two 2x2 blocks side by side, one full scale
  task automatic test_two_by_two_blocks();
    logic [TDATA_W-1:0] px [8] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0403_0201,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0080, 32'h00FF_0001};
    program_regs(4, 2, 2, 1, 2, 2);
    tx_steady = 1'b0;
    foreach (px[i]) send_pixel(px[i]);
    wait_drained();
  endtask

  // zero registers act as one; then blocks that run past the source edge
  task automatic test_register_limits();
    program_regs(0, 0, 0, 0, 0, 0);
    repeat (2) send_pixel(random_pixel());
    wait_drained();
    program_regs(3, 3, 2, 2, 2, 2);
    repeat (9) send_pixel(random_pixel());
    wait_drained();
  endtask

  // oversized scale clamps to 16: one 16x16 block at full scale
  task automatic test_largest_block();
    program_regs(16, 16, 1, 1, 31, 16);
    tx_steady = 1'b1;
    repeat (256) send_pixel({TDATA_W{1'b1}});
    wait_drained();
  endtask

  // oversized widths clamp: output columns stop at the accumulator depth
  task automatic test_clamped_wide_row();
    program_regs(8191, 8191, 2047, 2047, 1, 1);
    tx_steady = 1'b0;
    repeat (DEF_MAX_OUT_WIDTH + 6) send_pixel(random_pixel());
    wait_drained();
  endtask

  // long output stall with the sender still pushing
  task automatic test_output_backpressure();
    program_regs(8, 4, 8, 4, 1, 1);
    tx_steady = 1'b1;
    holds_requested++;
    repeat (96) send_pixel(random_pixel());
    wait_drained();
  endtask

  // random setups: matched, padded and short sources, whole and cut frames
  task automatic test_random_frames();
    int unsigned sx, sy, ow, oh, sw, sh, frame_px, count;
    int start_px;
    start_px = pixels_sent;
    while (pixels_sent - start_px < 250) begin
      sx = pick_scale();
      sy = pick_scale();
      ow = $urandom_range(1, (sx <= 3) ? 6 : 2);
      oh = $urandom_range(1, (sy <= 3) ? 4 : 1);
      sw = ow * sx;
      sh = oh * sy;
      case ($urandom_range(0, 7))
        0, 1: sw += $urandom_range(1, 3);
        2: if (sw > 1) sw--;
        3: sh += $urandom_range(1, 2);
        4: if (sh > 1) sh--;
        default: ;
      endcase
      frame_px = sw * sh;
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_px)
                                           : frame_px * $urandom_range(1, 2);
      tx_steady = ($urandom_range(0, 2) == 0);
      // a zero scale behaves as one
      if (sx == 1 && $urandom_range(0, 3) == 0) begin
        program_regs(sw, sh, ow, oh, 0, sy);
      end else begin
        program_regs(sw, sh, ow, oh, sx, sy);
      end
      repeat (count) send_pixel(random_pixel());
      wait_drained();
    end
  endtask

  // output ready: long hold on request, else a pattern that changes over time
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(16, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  // compare each output request with the oldest queued mean
  always @(posedge clk) begin : check_results
    avg_pixel_t got, want;
    string ch_name [CH_N];
    ch_name = '{"avg_red", "avg_green", "avg_blue", "avg_alpha"};
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata};
      if (expected_avgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = expected_avgs.pop_front();
        results_checked++;
        for (int ch = 0; ch < CH_N; ch++) begin
          if (got[ch*PIX_W +: PIX_W] !== want[ch*PIX_W +: PIX_W]) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, ch_name[ch],
                     want[ch*PIX_W +: PIX_W], got[ch*PIX_W +: PIX_W]);
          end
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last_of_image mismatch, expected %b, actual %b", $time,
                   want.last, got.last);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("box_filter_downscale_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unity_defaults();
    test_two_by_two_blocks();
    test_register_limits();
    test_largest_block();
    test_clamped_wide_row();
    test_output_backpressure();
    test_random_frames();
    $display("%0d source pixels over %0d register setups, %0d averaged pixels checked",
             pixels_sent, setups, results_checked);
    $display("1x1 to 16x16 blocks, clamped and zero registers, short sources, long stall");
    if (errors == 0) begin
      $display("box_filter_downscale_core verification clean");
    end else begin
      $display("box_filter_downscale_core verification failed");
    end
    $finish;
  end

endmodule
